/* rtl/qmr_pkg.sv */
// ----------------------------------------------------------------------------
// qmr_pkg
// Shared widths, divider lane types and constants of the quaternion unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qmr_pkg;

  localparam int NUM_W = 50;
  localparam int DEN_W = 34;
  localparam int D_W   = 51;
  localparam int Q_W   = 17;
  localparam int LANES = 4;

  localparam logic [DEN_W-1:0] DEN_PRODUCT = DEN_W'(32768);
  localparam logic [DEN_W-1:0] DEN_ZERO_LEN = DEN_W'(2);

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   low;
    logic [Q_W-1:0]   quo;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic [DEN_W-1:0]  den;
    logic              zl;
  } div_stage_t;

endpackage

`default_nettype wire

/* rtl/quaternion_multiply_rotate.sv */
// ----------------------------------------------------------------------------
// quaternion_multiply_rotate
// Fixed-point Hamilton product and vector rotation with a pipelined divider.
// Throughput: one beat per cycle while out_ready is high; the 17-stage restoring divider sets depth.
// Each stage holds its beat until the next stage frees; bubbles collapse.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_multiply_rotate
  import qmr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               mode,
  input  wire logic signed [15:0] q_w,
  input  wire logic signed [15:0] q_x,
  input  wire logic signed [15:0] q_y,
  input  wire logic signed [15:0] q_z,
  input  wire logic signed [15:0] r_w,
  input  wire logic signed [15:0] r_x,
  input  wire logic signed [15:0] r_y,
  input  wire logic signed [15:0] r_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_w,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic signed [15:0]      out_z,
  output logic                    zero_length,
  output logic                    saturated
);

  localparam int DIV0 = 5;
  localparam int NSTG = DIV0 + Q_W + 2;
  localparam int OUTS = NSTG - 1;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] go;
  logic [NSTG-1:0] vld_in;

  always_comb begin
    go[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      go[k] = !vld[k] || go[k+1];
    end
  end

  assign vld_in = {vld[NSTG-2:0], in_valid};
  assign in_ready = go[0];
  assign out_valid = vld[OUTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (go[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  // Input register.
  logic               a_mode;
  logic signed [15:0] a_w, a_x, a_y, a_z, a_rw, a_rx, a_ry, a_rz;

  always_ff @(posedge clk) begin
    if (go[0]) begin
      a_mode <= mode;
      a_w <= q_w; a_x <= q_x; a_y <= q_y; a_z <= q_z;
      a_rw <= r_w; a_rx <= r_x; a_ry <= r_y; a_rz <= r_z;
    end
  end

  // Raw 16x16 products.
  logic               b_mode;
  logic signed [15:0] b_w, b_x, b_y, b_z, b_rx, b_ry, b_rz;
  logic signed [31:0] b_wrw, b_xrx, b_yry, b_zrz;
  logic signed [31:0] b_wrx, b_xrw, b_yrz, b_zry;
  logic signed [31:0] b_wry, b_yrw, b_zrx, b_xrz;
  logic signed [31:0] b_wrz, b_zrw, b_xry, b_yrx;
  logic signed [31:0] b_ww, b_xx, b_yy, b_zz;

  always_ff @(posedge clk) begin
    if (go[1]) begin
      b_mode <= a_mode;
      b_w <= a_w; b_x <= a_x; b_y <= a_y; b_z <= a_z;
      b_rx <= a_rx; b_ry <= a_ry; b_rz <= a_rz;
      b_wrw <= 32'(a_w) * 32'(a_rw); b_xrx <= 32'(a_x) * 32'(a_rx);
      b_yry <= 32'(a_y) * 32'(a_ry); b_zrz <= 32'(a_z) * 32'(a_rz);
      b_wrx <= 32'(a_w) * 32'(a_rx); b_xrw <= 32'(a_x) * 32'(a_rw);
      b_yrz <= 32'(a_y) * 32'(a_rz); b_zry <= 32'(a_z) * 32'(a_ry);
      b_wry <= 32'(a_w) * 32'(a_ry); b_yrw <= 32'(a_y) * 32'(a_rw);
      b_zrx <= 32'(a_z) * 32'(a_rx); b_xrz <= 32'(a_x) * 32'(a_rz);
      b_wrz <= 32'(a_w) * 32'(a_rz); b_zrw <= 32'(a_z) * 32'(a_rw);
      b_xry <= 32'(a_x) * 32'(a_ry); b_yrx <= 32'(a_y) * 32'(a_rx);
      b_ww <= 32'(a_w) * 32'(a_w); b_xx <= 32'(a_x) * 32'(a_x);
      b_yy <= 32'(a_y) * 32'(a_y); b_zz <= 32'(a_z) * 32'(a_z);
    end
  end

  // Sums of products.
  logic               c_mode;
  logic signed [15:0] c_w, c_x, c_y, c_z, c_rx, c_ry, c_rz;
  logic signed [33:0] c_pw, c_px, c_py, c_pz;
  logic signed [33:0] c_n, c_s, c_dot, c_cx, c_cy, c_cz;

  always_ff @(posedge clk) begin
    if (go[2]) begin
      c_mode <= b_mode;
      c_w <= b_w; c_x <= b_x; c_y <= b_y; c_z <= b_z;
      c_rx <= b_rx; c_ry <= b_ry; c_rz <= b_rz;
      c_pw <= 34'(b_wrw) - 34'(b_xrx) - 34'(b_yry) - 34'(b_zrz);
      c_px <= 34'(b_wrx) + 34'(b_xrw) + 34'(b_yrz) - 34'(b_zry);
      c_py <= 34'(b_wry) + 34'(b_yrw) + 34'(b_zrx) - 34'(b_xrz);
      c_pz <= 34'(b_wrz) + 34'(b_zrw) + 34'(b_xry) - 34'(b_yrx);
      c_n <= 34'(b_ww) + 34'(b_xx) + 34'(b_yy) + 34'(b_zz);
      c_s <= 34'(b_ww) - 34'(b_xx) - 34'(b_yy) - 34'(b_zz);
      c_dot <= 34'(b_xrx) + 34'(b_yry) + 34'(b_zrz);
      c_cx <= 34'(b_yrz) - 34'(b_zry);
      c_cy <= 34'(b_zrx) - 34'(b_xrz);
      c_cz <= 34'(b_xry) - 34'(b_yrx);
    end
  end

  // Rotation products.
  logic                    d_mode;
  logic signed [33:0]      d_pw, d_px, d_py, d_pz, d_n;
  logic signed [NUM_W-1:0] d_sx, d_sy, d_sz, d_ux, d_uy, d_uz, d_cx, d_cy, d_cz;

  always_ff @(posedge clk) begin
    if (go[3]) begin
      d_mode <= c_mode;
      d_pw <= c_pw; d_px <= c_px; d_py <= c_py; d_pz <= c_pz; d_n <= c_n;
      d_sx <= NUM_W'(c_s) * NUM_W'(c_rx);
      d_sy <= NUM_W'(c_s) * NUM_W'(c_ry);
      d_sz <= NUM_W'(c_s) * NUM_W'(c_rz);
      d_ux <= NUM_W'(c_dot) * NUM_W'(c_x);
      d_uy <= NUM_W'(c_dot) * NUM_W'(c_y);
      d_uz <= NUM_W'(c_dot) * NUM_W'(c_z);
      d_cx <= NUM_W'(c_cx) * NUM_W'(c_w);
      d_cy <= NUM_W'(c_cy) * NUM_W'(c_w);
      d_cz <= NUM_W'(c_cz) * NUM_W'(c_w);
    end
  end

  // Numerators and divisor.
  logic signed [NUM_W-1:0] e_num [LANES];
  logic [DEN_W-1:0]        e_den;
  logic                    e_zl;

  always_ff @(posedge clk) begin
    if (go[4]) begin
      e_zl <= d_mode && (d_n == '0);
      if (d_mode) begin
        e_num[0] <= '0;
        e_num[1] <= d_sx + (d_ux <<< 1) + (d_cx <<< 1);
        e_num[2] <= d_sy + (d_uy <<< 1) + (d_cy <<< 1);
        e_num[3] <= d_sz + (d_uz <<< 1) + (d_cz <<< 1);
        e_den <= (d_n == '0) ? DEN_ZERO_LEN : {d_n[DEN_W-2:0], 1'b0};
      end else begin
        e_num[0] <= NUM_W'(d_pw);
        e_num[1] <= NUM_W'(d_px);
        e_num[2] <= NUM_W'(d_py);
        e_num[3] <= NUM_W'(d_pz);
        e_den <= DEN_PRODUCT;
      end
    end
  end

  // Divider entry: magnitude, rounding offset and range check.
  div_stage_t div_st [Q_W+1];
  div_stage_t div_first;

  always_comb begin
    logic [NUM_W-1:0] mag;
    logic [D_W-1:0]   dd;
    div_first.den = e_den;
    div_first.zl = e_zl;
    for (int i = 0; i < LANES; i++) begin
      mag = e_num[i][NUM_W-1] ? NUM_W'(-e_num[i]) : NUM_W'(e_num[i]);
      dd = {mag, 1'b0} + {18'b0, e_den[DEN_W-1:1]};
      div_first.lane[i].neg = e_num[i][NUM_W-1];
      div_first.lane[i].ovf = dd[D_W-1:Q_W] >= e_den;
      div_first.lane[i].rem = dd[D_W-1:Q_W];
      div_first.lane[i].low = dd[Q_W-1:0];
      div_first.lane[i].quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (go[DIV0]) begin
      div_st[0] <= div_first;
    end
  end

  for (genvar g = 0; g < Q_W; g++) begin : g_div
    qmr_div_step u_step (
      .clk (clk),
      .en  (go[DIV0+1+g]),
      .d   (div_st[g]),
      .q   (div_st[g+1])
    );
  end

  // Saturation and output register.
  logic signed [15:0] res_next [LANES];
  logic               sat_next;

  always_comb begin
    lane_t       ln;
    logic [Q_W-1:0] qv;
    logic        big;
    sat_next = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      ln = div_st[Q_W].lane[i];
      qv = ln.quo;
      if (ln.neg) begin
        big = ln.ovf || qv[16] || (qv[15] && (qv[14:0] != '0));
        res_next[i] = big ? 16'sh8000 : 16'(~qv + 17'd1);
      end else begin
        big = ln.ovf || qv[16] || qv[15];
        res_next[i] = big ? 16'sh7fff : qv[15:0];
      end
      sat_next = sat_next || big;
    end
  end

  always_ff @(posedge clk) begin
    if (go[OUTS]) begin
      zero_length <= div_st[Q_W].zl;
      if (div_st[Q_W].zl) begin
        out_w <= '0; out_x <= '0; out_y <= '0; out_z <= '0;
        saturated <= 1'b0;
      end else begin
        out_w <= res_next[0]; out_x <= res_next[1];
        out_y <= res_next[2]; out_z <= res_next[3];
        saturated <= sat_next;
      end
    end
  end

  a_zero_len_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_length |-> out_w == 0 && out_x == 0 && out_y == 0 && out_z == 0
      && !saturated)
    else $error("zero length result carries data");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pipeline refuses a beat while its output is empty");

  a_hold_output: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(saturated))
    else $error("stalled result changed");

endmodule

`default_nettype wire

/* rtl/qmr_div_step.sv */
// ----------------------------------------------------------------------------
// qmr_div_step
// One registered restoring division step for all four result lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module qmr_div_step
  import qmr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       en,
  input  wire div_stage_t d,
  output div_stage_t      q
);

  div_stage_t q_next;

  always_comb begin
    logic [DEN_W:0] trial;
    q_next = d;
    for (int i = 0; i < LANES; i++) begin
      trial = {d.lane[i].rem, d.lane[i].low[Q_W-1]};
      if (trial >= {1'b0, d.den}) begin
        q_next.lane[i].rem = DEN_W'(trial - {1'b0, d.den});
        q_next.lane[i].quo = {d.lane[i].quo[Q_W-2:0], 1'b1};
      end else begin
        q_next.lane[i].rem = trial[DEN_W-1:0];
        q_next.lane[i].quo = {d.lane[i].quo[Q_W-2:0], 1'b0};
      end
      q_next.lane[i].low = {d.lane[i].low[Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

/* sim/quaternion_multiply_rotate_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_multiply_rotate_chk
// Watches both channels of the quaternion unit, predicts every result beat
// from the accepted input beat with exact integer arithmetic, and compares.
// ----------------------------------------------------------------------------
module quaternion_multiply_rotate_chk (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               mode,
  input  logic signed [15:0] q_w,
  input  logic signed [15:0] q_x,
  input  logic signed [15:0] q_y,
  input  logic signed [15:0] q_z,
  input  logic signed [15:0] r_w,
  input  logic signed [15:0] r_x,
  input  logic signed [15:0] r_y,
  input  logic signed [15:0] r_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_w,
  input  logic signed [15:0] out_x,
  input  logic signed [15:0] out_y,
  input  logic signed [15:0] out_z,
  input  logic               zero_length,
  input  logic               saturated,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               zl;
    logic               sat;
  } quat_res_t;

  quat_res_t results_due[$];

  initial errors = 0;
  initial pending = 0;

  function automatic longint round_div(longint num, longint d);
    longint mag;
    longint qv;
    mag = (num < 0) ? -num : num;
    qv = (2 * mag + d) / (2 * d);
    return (num < 0) ? -qv : qv;
  endfunction

  function automatic logic signed [15:0] clip16(longint v, inout logic sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic quat_res_t quat_compute(logic m, longint w, longint x, longint y,
                                             longint z, longint rw, longint rx,
                                             longint ry, longint rz);
    quat_res_t res;
    logic sat;
    longint ww, uu, n, s, dt, cx, cy, cz;
    res = '0;
    sat = 1'b0;
    if (!m) begin
      res.w = clip16(round_div(w*rw - x*rx - y*ry - z*rz, 16384), sat);
      res.x = clip16(round_div(w*rx + x*rw + y*rz - z*ry, 16384), sat);
      res.y = clip16(round_div(w*ry + y*rw + z*rx - x*rz, 16384), sat);
      res.z = clip16(round_div(w*rz + z*rw + x*ry - y*rx, 16384), sat);
    end else begin
      ww = w * w;
      uu = x*x + y*y + z*z;
      n = ww + uu;
      if (n == 0) begin
        res.zl = 1'b1;
        return res;
      end
      s = ww - uu;
      dt = x*rx + y*ry + z*rz;
      cx = y*rz - z*ry;
      cy = z*rx - x*rz;
      cz = x*ry - y*rx;
      res.x = clip16(round_div(s*rx + 2*dt*x + 2*w*cx, n), sat);
      res.y = clip16(round_div(s*ry + 2*dt*y + 2*w*cy, n), sat);
      res.z = clip16(round_div(s*rz + 2*dt*z + 2*w*cz, n), sat);
    end
    res.sat = sat;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    quat_res_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        results_due.push_back(quat_compute(mode, q_w, q_x, q_y, q_z, r_w, r_x, r_y, r_z));
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = results_due.pop_front();
          if (out_w != want.w) report_mismatch("out_w", out_w, want.w);
          if (out_x != want.x) report_mismatch("out_x", out_x, want.x);
          if (out_y != want.y) report_mismatch("out_y", out_y, want.y);
          if (out_z != want.z) report_mismatch("out_z", out_z, want.z);
          if (zero_length != want.zl) report_mismatch("zero_length", zero_length, want.zl);
          if (saturated != want.sat) report_mismatch("saturated", saturated, want.sat);
        end
      end
    end
    pending <= results_due.size();
  end

endmodule

/* sim/quaternion_multiply_rotate_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_multiply_rotate_tb
// Drives directed and random quaternion beats into the unit under changing
// idle patterns and a long output hold-off; the checker judges every result.
// ----------------------------------------------------------------------------
module quaternion_multiply_rotate_tb;

  localparam int RANDOM_BEATS = 1330;
  localparam int CYCLE_LIMIT  = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               mode = 1'b0;
  logic signed [15:0] q_w = '0, q_x = '0, q_y = '0, q_z = '0;
  logic signed [15:0] r_w = '0, r_x = '0, r_y = '0, r_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_w, out_x, out_y, out_z;
  logic               zero_length, saturated;
  int                 errors, pending;
  int                 send_idle_pct = 7;
  int                 recv_idle_pct = 71;
  logic               hold_off = 1'b0;
  int                 cycles = 0;

  always #4 clk = ~clk;

  quaternion_multiply_rotate dut (.*);
  quaternion_multiply_rotate_chk chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk)
    out_ready <= !rst && !hold_off && ($urandom_range(99) >= recv_idle_pct);

  function automatic int pick_val();
    case ($urandom_range(5))
      0: return 32767;
      1: return -32768;
      2: return 16384;
      3: return int'($urandom_range(7)) - 4;
      4: return int'($urandom_range(32768)) - 16384;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic send_beat(int m, int a, int b, int c, int d, int e, int f, int g, int h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= 1'(m);
    q_w <= 16'(a); q_x <= 16'(b); q_y <= 16'(c); q_z <= 16'(d);
    r_w <= 16'(e); r_x <= 16'(f); r_y <= 16'(g); r_z <= 16'(h);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    int m;
    for (int i = 0; i < count; i++) begin
      m = int'($urandom_range(1));
      if ($urandom_range(19) == 0)
        send_beat(m, 0, 0, 0, 0, pick_val(), pick_val(), pick_val(), pick_val());
      else
        send_beat(m, pick_val(), pick_val(), pick_val(), pick_val(),
                  pick_val(), pick_val(), pick_val(), pick_val());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_beat(0, 16384, 0, 0, 0, 16384, 0, 0, 0);
    send_beat(0, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_beat(0, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_beat(0, -32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768);
    send_beat(0, 1, 0, 0, 0, 8192, 0, 0, 0);
    send_beat(0, 1, 0, 0, 0, -8192, 0, 0, 0);
    send_beat(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_beat(1, 0, 0, 0, 0, 32767, 32767, -32768, 100);
    send_beat(1, 16384, 0, 0, 0, -32768, 32767, -32768, 32767);
    send_beat(1, 11585, 0, 0, 11585, 1234, 640, -640, 64);
    send_beat(1, 0, 0, 0, 1, 0, -32768, 32767, 5);
    send_beat(1, 1, 1, 1, 1, 0, 32767, 32767, 32767);
    send_beat(1, -32768, -32768, 32767, 32767, -32768, -32768, -32768, -32768);
    send_beat(1, 3, 0, 0, 0, 0, 1, -1, 2);
    send_random(RANDOM_BEATS / 3);
    send_idle_pct = 71;
    recv_idle_pct = 7;
    send_random(RANDOM_BEATS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
      end
      send_random(RANDOM_BEATS / 3);
    join
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/qmr_pkg.sv
rtl/qmr_div_step.sv
rtl/quaternion_multiply_rotate.sv
sim/quaternion_multiply_rotate_chk.sv
sim/quaternion_multiply_rotate_tb.sv
